/* src/dbam_pkg.sv */
// dbam_pkg: command, status and controller state codes for the disk block availability map
// fixed field widths of the item payloads
// no dependencies
package dbam_pkg;

  localparam int CMD_W    = 3;
  localparam int TRACK_W  = 7;
  localparam int SECTOR_W = 6;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 12;
  localparam int CNT_W    = 6;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 3'd0,
    CMD_FREE   = 3'd1,
    CMD_FIND   = 3'd2,
    CMD_COUNT  = 3'd3,
    CMD_FORMAT = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 3'd0,
    STS_USED    = 3'd1,
    STS_FREE    = 3'd2,
    STS_NOFREE  = 3'd3,
    STS_DIRERR  = 3'd4,
    STS_BADADDR = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RMW,
    S_SIMPLE,
    S_GROUP,
    S_PICK,
    S_LOOKUP,
    S_LOWBIT
  } state_t;

endpackage

/* src/disk_block_availability_map.sv */
// disk_block_availability_map: per-track free bitmaps and counts in one synchronous memory,
// read-modify-write controller, two-level search for the first free block
// depends on dbam_pkg
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   cmd, track, sector
// m_axis    out  m_axis_tvalid/m_axis_tready   status, found_track, found_sector, free_total
//
// one item at a time: allocate and free read the memory, then modify and write it back;
// find free goes through a group scan of the nonzero flags, pick, memory read, byte scan and select;
// count, format, bad address and unknown commands go straight to their result step
// the result sits in an output register; the next item is taken while it waits there
// reset and format clear the per-track valid flags at once, so no clearing pass is needed
// a final step stalls only while the output register is still full
module disk_block_availability_map #(
  parameter int NUM_TRACKS        = 80,
  parameter int SECTORS_PER_TRACK = 40,
  parameter int DIRECTORY_TRACK   = 40
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [dbam_pkg::IN_W-1:0]   s_axis_tdata,   // cmd[2:0], track[9:3], sector[15:10]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [dbam_pkg::OUT_W-1:0]  m_axis_tdata    // status[2:0], found_track[9:3],
                                                      // found_sector[15:10], free_total[27:16]
);

  localparam int N     = NUM_TRACKS;
  localparam int S     = SECTORS_PER_TRACK;
  localparam int D     = DIRECTORY_TRACK;
  localparam int CW    = dbam_pkg::CNT_W;
  localparam int AW    = $clog2(N);
  localparam int SIW   = $clog2(S);
  localparam int MW    = S + CW;
  localparam int NB    = (D - 1 < N) ? D - 1 : N;
  localparam int NPOS  = (D <= N) ? N - 1 : N;
  localparam int NGRP  = (NPOS + 7) / 8;
  localparam int NBYTE = (S + 7) / 8;
  localparam int RESET_SUM = NPOS * S;
  localparam logic [S-1:0] FULL = '1;

  // item fields
  logic [dbam_pkg::CMD_W-1:0]    in_cmd;
  logic [dbam_pkg::TRACK_W-1:0]  in_trk;
  logic [dbam_pkg::SECTOR_W-1:0] in_sec;
  logic                          in_acc;
  logic                          in_addr_ok;

  assign in_cmd = s_axis_tdata[2:0];
  assign in_trk = s_axis_tdata[9:3];
  assign in_sec = s_axis_tdata[15:10];
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign in_addr_ok = (in_trk != '0) && (int'(in_trk) <= N) && (int'(in_sec) < S);

  dbam_pkg::state_t state, state_next;

  logic [dbam_pkg::CMD_W-1:0]    cmd_q;
  logic [dbam_pkg::TRACK_W-1:0]  trk_q;
  logic [dbam_pkg::SECTOR_W-1:0] sec_q;
  logic                          bad_q;

  logic [N-1:0]                  vld;
  logic [N-1:0]                  nz;
  logic [dbam_pkg::TOTAL_W-1:0]  free_sum;

  // track memory: {count, bitmap}
  logic [MW-1:0] mem [N];
  logic [MW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          rd_vld;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [MW-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
      rd_addr <= mem_ra;
      rd_vld  <= vld[mem_ra];
    end
  end

  // entry as seen through the valid flag
  logic          rd_is_dir;
  logic [S-1:0]  eff_bm;
  logic [CW-1:0] eff_cnt;

  assign rd_is_dir = (int'(rd_addr) + 1 == D);
  assign eff_bm  = rd_vld ? rd_data[S-1:0] : (rd_is_dir ? (FULL & ~S'(7)) : FULL);
  assign eff_cnt = rd_vld ? rd_data[MW-1:S] : (rd_is_dir ? CW'(S - 3) : CW'(S));

  // nonzero flags in search order
  logic [NPOS-1:0]     ord;
  logic [NGRP*8-1:0]   ord_pad;

  for (genvar t = 1; t <= N; t++) begin : g_ord
    if (t < D) begin : g_lo
      assign ord[NB - t] = nz[t-1];
    end else if (t > D) begin : g_hi
      assign ord[NB + t - D - 1] = nz[t-1];
    end
  end
  assign ord_pad = (NGRP*8)'(ord);

  logic [NGRP-1:0] grp_any, grp_any_c;
  logic [2:0]      grp_idx [NGRP];
  logic [2:0]      grp_idx_c [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_c[g] = 1'b0;
      grp_idx_c[g] = '0;
      for (int j = 7; j >= 0; j--) begin
        if (ord_pad[g*8 + j]) begin
          grp_any_c[g] = 1'b1;
          grp_idx_c[g] = 3'(j);
        end
      end
    end
  end

  logic                         pick_any;
  logic [7:0]                   pick_pos;
  logic [dbam_pkg::TRACK_W-1:0] pick_trk;

  always_comb begin
    pick_any = 1'b0;
    pick_pos = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        pick_any = 1'b1;
        pick_pos = 8'(g * 8) + 8'(grp_idx[g]);
      end
    end
    if (int'(pick_pos) < NB) begin
      pick_trk = 7'(NB - int'(pick_pos));
    end else begin
      pick_trk = 7'(int'(pick_pos) - NB + D + 1);
    end
  end

  logic                         fnd_any;
  logic [dbam_pkg::TRACK_W-1:0] fnd_trk;

  // lowest free sector, byte groups
  logic [NBYTE*8-1:0] bm_pad;
  logic [NBYTE-1:0]   byte_any, byte_any_c;
  logic [2:0]         byte_idx [NBYTE];
  logic [2:0]         byte_idx_c [NBYTE];

  assign bm_pad = (NBYTE*8)'(eff_bm);

  always_comb begin
    for (int b = 0; b < NBYTE; b++) begin
      byte_any_c[b] = 1'b0;
      byte_idx_c[b] = '0;
      for (int j = 7; j >= 0; j--) begin
        if (bm_pad[b*8 + j]) begin
          byte_any_c[b] = 1'b1;
          byte_idx_c[b] = 3'(j);
        end
      end
    end
  end

  logic                          low_any;
  logic [dbam_pkg::SECTOR_W-1:0] low_sec;

  always_comb begin
    low_any = 1'b0;
    low_sec = '0;
    for (int b = NBYTE - 1; b >= 0; b--) begin
      if (byte_any[b]) begin
        low_any = 1'b1;
        low_sec = 6'(b * 8) + 6'(byte_idx[b]);
      end
    end
  end

  // read-modify-write of one track entry
  logic          bit_free;
  logic          is_alloc;
  logic          rmw_ok;
  logic [S-1:0]  sec_bit;
  logic [S-1:0]  new_bm;
  logic [CW-1:0] new_cnt;
  logic          cnt_moved;

  assign is_alloc = (cmd_q == dbam_pkg::CMD_ALLOC);
  assign sec_bit  = S'(1) << sec_q[SIW-1:0];
  assign bit_free = eff_bm[sec_q[SIW-1:0]];
  assign rmw_ok   = is_alloc ? bit_free : !bit_free;

  always_comb begin
    if (is_alloc) begin
      new_bm    = eff_bm & ~sec_bit;
      cnt_moved = (eff_cnt != '0);
      new_cnt   = cnt_moved ? eff_cnt - CW'(1) : eff_cnt;
    end else begin
      new_bm    = eff_bm | sec_bit;
      cnt_moved = (eff_cnt != dbam_pkg::CNT_MAX);
      new_cnt   = cnt_moved ? eff_cnt + CW'(1) : eff_cnt;
    end
  end

  // controller
  logic                          res_ld;
  logic                          res_room;
  dbam_pkg::status_t             res_status;
  logic [dbam_pkg::TRACK_W-1:0]  res_trk;
  logic [dbam_pkg::SECTOR_W-1:0] res_sec;
  logic [dbam_pkg::TOTAL_W-1:0]  sum_next;
  logic                          fmt_ld;

  assign res_room = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    res_ld        = 1'b0;
    res_status    = dbam_pkg::STS_OK;
    res_trk       = '0;
    res_sec       = '0;
    sum_next      = free_sum;
    fmt_ld        = 1'b0;
    mem_re        = 1'b0;
    mem_ra        = AW'(in_trk - 7'd1);
    mem_we        = 1'b0;
    mem_wa        = AW'(trk_q - 7'd1);
    mem_wd        = {new_cnt, new_bm};
    unique case (state)
      dbam_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_acc) begin
          unique case (in_cmd)
            dbam_pkg::CMD_ALLOC, dbam_pkg::CMD_FREE: begin
              mem_re     = in_addr_ok;
              state_next = in_addr_ok ? dbam_pkg::S_RMW : dbam_pkg::S_SIMPLE;
            end
            dbam_pkg::CMD_FIND: state_next = dbam_pkg::S_GROUP;
            default:            state_next = dbam_pkg::S_SIMPLE;
          endcase
        end
      end
      dbam_pkg::S_RMW: begin
        res_status = rmw_ok ? dbam_pkg::STS_OK
                   : (is_alloc ? dbam_pkg::STS_USED : dbam_pkg::STS_FREE);
        if (rmw_ok && cnt_moved && int'(trk_q) != D) begin
          sum_next = is_alloc ? free_sum - 12'd1 : free_sum + 12'd1;
        end
        if (res_room) begin
          res_ld     = 1'b1;
          mem_we     = rmw_ok;
          state_next = dbam_pkg::S_IDLE;
        end
      end
      dbam_pkg::S_SIMPLE: begin
        res_status = bad_q ? dbam_pkg::STS_BADADDR : dbam_pkg::STS_OK;
        if (cmd_q == dbam_pkg::CMD_FORMAT && !bad_q) begin
          sum_next = dbam_pkg::TOTAL_W'(RESET_SUM);
        end
        if (res_room) begin
          res_ld     = 1'b1;
          fmt_ld     = (cmd_q == dbam_pkg::CMD_FORMAT) && !bad_q;
          state_next = dbam_pkg::S_IDLE;
        end
      end
      dbam_pkg::S_GROUP: state_next = dbam_pkg::S_PICK;
      dbam_pkg::S_PICK: begin
        mem_re     = pick_any;
        mem_ra     = AW'(pick_trk - 7'd1);
        state_next = dbam_pkg::S_LOOKUP;
      end
      dbam_pkg::S_LOOKUP: state_next = dbam_pkg::S_LOWBIT;
      dbam_pkg::S_LOWBIT: begin
        if (!fnd_any) begin
          res_status = dbam_pkg::STS_NOFREE;
        end else if (!low_any) begin
          res_status = dbam_pkg::STS_DIRERR;
        end else begin
          res_trk = fnd_trk;
          res_sec = low_sec;
        end
        if (res_room) begin
          res_ld     = 1'b1;
          state_next = dbam_pkg::S_IDLE;
        end
      end
      default: state_next = dbam_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dbam_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld           <= '0;
      nz            <= '1;
      free_sum      <= dbam_pkg::TOTAL_W'(RESET_SUM);
      m_axis_tvalid <= 1'b0;
    end else begin
      if (res_ld) begin
        m_axis_tvalid <= 1'b1;
        free_sum      <= sum_next;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (mem_we) begin
        vld[mem_wa] <= 1'b1;
        nz[mem_wa]  <= (new_cnt != '0);
      end
      if (fmt_ld) begin
        vld <= '0;
        nz  <= '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_q <= in_cmd;
      trk_q <= in_trk;
      sec_q <= in_sec;
      bad_q <= (in_cmd == dbam_pkg::CMD_ALLOC || in_cmd == dbam_pkg::CMD_FREE) && !in_addr_ok;
    end
    if (state == dbam_pkg::S_GROUP) begin
      grp_any <= grp_any_c;
      grp_idx <= grp_idx_c;
    end
    if (state == dbam_pkg::S_PICK) begin
      fnd_any <= pick_any;
      fnd_trk <= pick_trk;
    end
    if (state == dbam_pkg::S_LOOKUP) begin
      byte_any <= byte_any_c;
      byte_idx <= byte_idx_c;
    end
    if (res_ld) begin
      m_axis_tdata <= {4'b0, sum_next, res_sec, res_trk, res_status};
    end
  end

  // sum of free counts never grows past the fresh map
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    int'(free_sum) <= RESET_SUM)
    else $error("free sum above fresh map total");

  // format drops every stored entry back to its fresh value
  a_fmt_clear: assert property (@(posedge clk) disable iff (rst)
    fmt_ld |=> (vld == '0) && (nz == '1))
    else $error("format left stored entries valid");

  // nonzero flag follows the count written back
  a_nz_track: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> nz[$past(mem_wa)] == ($past(mem_wd[MW-1:S]) != '0))
    else $error("nonzero flag out of step with track count");

  // a found sector lies on the track
  a_find_sec: assert property (@(posedge clk) disable iff (rst)
    (res_ld && state == dbam_pkg::S_LOWBIT && res_status == dbam_pkg::STS_OK)
      |-> (int'(res_sec) < S) && (res_trk != '0) && (int'(res_trk) != D))
    else $error("find result outside track");

  // no write-back outside a completing modify step
  a_we_rmw: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> res_ld && state == dbam_pkg::S_RMW)
    else $error("track memory written without a result");

endmodule
